// ===== src/sst_pkg.sv =====
`default_nettype none

package sst_pkg;

    // Request codes carried in the mode field.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_DUP      = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic        [1:0]  mode;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [4:0] position;
        logic [4:0] count;
    } rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // capture the request beat
        logic compare;  // register the per-cell compare flags
        logic commit;   // update the table and the result register
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

endpackage

`default_nettype wire

// ===== src/sorted_set_table.sv =====
`default_nettype none

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   sst_pkg::req_t  (mode, value)
// rsp      out        rsp_valid/rsp_stall   sst_pkg::rsp_t  (status, found, position, count)
//
// Each request passes through three steps: one to capture the beat, one in which every
// cell compares itself against the value, and one in which the cell chain shifts
// and the result register loads. The next request is taken the cycle after that.
// Reset empties the table by clearing the fill count; cell contents are don't-care.
// A stalled result holds the block in its update cycle until the beat drains.

module sorted_set_table #(
    parameter int DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire sst_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output sst_pkg::rsp_t      rsp
);
    import sst_pkg::*;

    cmd_t cmd;

    // The controller sequences capture, compare and commit for each beat and
    // owns the result valid flag.
    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // The datapath holds the sorted cell chain, the fill count and the
    // result register.
    sst_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== src/sst_ctrl.sv =====
`default_nettype none

module sst_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output sst_pkg::cmd_t      cmd
);
    import sst_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    // The result register can take a new beat when empty or when it drains now.
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
            end
            ST_UPD:
            begin
                cmd.commit = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== src/sst_dpath.sv =====
`default_nettype none

module sst_dpath #(
    parameter int DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sst_pkg::cmd_t cmd,
    input  wire sst_pkg::req_t req,
    output sst_pkg::rsp_t      rsp
);
    import sst_pkg::*;

    localparam int IW = $clog2(DEPTH + 1);

    logic        [1:0]      mode_reg;
    logic signed [31:0]     value_reg;
    logic signed [31:0]     cell_reg  [DEPTH];
    logic signed [31:0]     cell_next [DEPTH];
    logic        [IW-1:0]   count_reg;
    logic        [IW-1:0]   count_next;
    logic        [DEPTH-1:0] lt_reg;
    logic        [DEPTH-1:0] eq_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;

    logic [DEPTH-1:0] bound;
    logic [IW-1:0]    enc;
    logic [IW-1:0]    idx;
    logic [IW-1:0]    pos;
    logic             found;
    logic             is_ins;
    logic             is_rem;
    logic             do_ins;
    logic             do_rem;
    logic             full;

    // The stored cells are always ascending, so the less-than flags form a
    // prefix; the first cell that is not below the value marks the boundary.
    always_comb
    begin
        bound = '0;
        enc   = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (k == 0)
            begin
                bound[k] = !lt_reg[k];
            end
            else
            begin
                bound[k] = lt_reg[(k == 0) ? 0 : k - 1] && !lt_reg[k];
            end
            if (bound[k])
            begin
                enc = enc | IW'(k);
            end
        end
    end

    assign idx    = (|bound) ? enc : IW'(DEPTH);
    assign pos    = IW'(idx + IW'(1));
    assign found  = |eq_reg;
    assign full   = (count_reg == IW'(DEPTH));
    assign is_ins = (mode_reg == MODE_INSERT);
    assign is_rem = (mode_reg == MODE_REMOVE);
    assign do_ins = is_ins && !found && !full;
    assign do_rem = is_rem && found;

    // Each cell keeps its value, takes the new value, takes a neighbor, or (the last cell on a remove) is cleared.
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            cell_next[k] = cell_reg[k];
            if (do_ins && !lt_reg[k])
            begin
                if (bound[k] || k == 0)
                begin
                    cell_next[k] = value_reg;
                end
                else
                begin
                    cell_next[k] = cell_reg[(k == 0) ? 0 : k - 1];
                end
            end
            else if (do_rem && !lt_reg[k])
            begin
                if (k == DEPTH - 1)
                begin
                    cell_next[k] = '0;
                end
                else
                begin
                    cell_next[k] = cell_reg[(k == DEPTH - 1) ? k : k + 1];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = IW'(count_reg + IW'(1));
        end
        else if (do_rem)
        begin
            count_next = IW'(count_reg - IW'(1));
        end
    end

    always_comb
    begin
        rsp_next.found    = found;
        rsp_next.count    = 5'(count_next);
        rsp_next.position = '0;
        rsp_next.status   = STAT_DONE;
        priority if (is_ins)
        begin
            if (found)
            begin
                rsp_next.status   = STAT_DUP;
                rsp_next.position = 5'(pos);
            end
            else if (full)
            begin
                rsp_next.status = STAT_FULL;
            end
            else
            begin
                rsp_next.position = 5'(pos);
            end
        end
        else if (is_rem)
        begin
            if (!found)
            begin
                rsp_next.status = STAT_NOTFOUND;
            end
        end
        else
        begin
            if (found)
            begin
                rsp_next.position = 5'(pos);
            end
            else
            begin
                rsp_next.status = STAT_NOTFOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= req.mode;
            value_reg <= req.value;
        end
        if (cmd.compare)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                lt_reg[k] <= (count_reg > IW'(k)) && (cell_reg[k] < value_reg);
                eq_reg[k] <= (count_reg > IW'(k)) && (cell_reg[k] == value_reg);
            end
        end
        if (cmd.commit)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                cell_reg[k] <= cell_next[k];
            end
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire
